FILE: hw/rtl/sscs_pkg.sv
// Shared constants for the sparse-set component store.
// Operation and status codes, field widths and store sizes.
// No dependencies.
package sscs_pkg;

   localparam int MAX_ENTITIES = 256;
   localparam int NUM_TYPES    = 4;
   localparam int PEND_DEPTH   = 16;

   localparam int OP_W      = 3;
   localparam int ENT_W     = 8;
   localparam int TYPE_W    = 2;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = 9;
   localparam int SLOT_AW   = TYPE_W + ENT_W;
   localparam int PCNT_W    = 5;
   localparam int PIDX_W    = 4;
   localparam int SPARSE_W  = ENT_W + 1;
   localparam int SLOTS     = NUM_TYPES * MAX_ENTITIES;

   localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ   = 3'd3;
   localparam logic [OP_W-1:0] OP_MARK   = 3'd4;
   localparam logic [OP_W-1:0] OP_FLUSH  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

FILE: hw/rtl/sparse_set_component_store_top.sv
// Sparse-set entity/component store: sparse map, dense arrays, free stack.
// Depends on sscs_pkg.
// Allocate takes a new ID from the high-water counter or pops the free stack; add, read and
// remove look up the sparse map and then the dense arrays, and a remove that misses the last
// slot swaps the last entry in; mark and failed bound checks answer at once; flush skips each
// marked entity beyond the high-water mark and strips every other one. req_ready returns in the
// cycle after the result is loaded; a held result stalls it. One item at a time. After reset a
// clearing pass over every sparse-map slot invalidates the map before req_ready rises.
module sparse_set_component_store_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sscs_pkg::OP_W-1:0]          req_operation,
   input  logic [sscs_pkg::ENT_W-1:0]         req_entity,
   input  logic [sscs_pkg::TYPE_W-1:0]        req_component_type,
   input  logic [sscs_pkg::DATA_W-1:0]        req_component_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sscs_pkg::STATUS_W-1:0]      rsp_status,
   output logic [sscs_pkg::ENT_W-1:0]         rsp_entity_id,
   output logic [sscs_pkg::DATA_W-1:0]        rsp_read_data
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_ALLOC_RD, S_LK_ISSUE, S_LK_SP, S_LK_DE,
      S_RM_MOVE, S_RM_INV, S_FL_ENT, S_FL_PUSH, S_RESP
   } state_type;

   state_type state_ff;
   logic [sscs_pkg::OP_W-1:0]     op_ff;
   logic [sscs_pkg::ENT_W-1:0]    cur_e_ff;
   logic [sscs_pkg::TYPE_W-1:0]   cur_t_ff;
   logic [sscs_pkg::DATA_W-1:0]   data_ff;
   logic [sscs_pkg::ENT_W-1:0]    slot_ff;
   logic                          spv_ff;
   logic [sscs_pkg::STATUS_W-1:0] res_status_ff;
   logic [sscs_pkg::ENT_W-1:0]    res_id_ff;
   logic [sscs_pkg::DATA_W-1:0]   res_rd_ff;
   logic [sscs_pkg::CNT_W-1:0]    cnt_ff [sscs_pkg::NUM_TYPES];
   logic [sscs_pkg::CNT_W-1:0]    fc_ff;
   logic [sscs_pkg::CNT_W-1:0]    hw_ff;
   logic [sscs_pkg::ENT_W-1:0]    pq_ff [sscs_pkg::PEND_DEPTH];
   logic [sscs_pkg::PCNT_W-1:0]   pc_ff;
   logic [sscs_pkg::PCNT_W-1:0]   idx_ff;
   logic [sscs_pkg::SLOT_AW-1:0]  clr_ff;
   logic                          rsp_valid_ff;
   logic [sscs_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [sscs_pkg::ENT_W-1:0]    rsp_id_ff;
   logic [sscs_pkg::DATA_W-1:0]   rsp_rd_ff;

   // memories
   logic [sscs_pkg::SPARSE_W-1:0] sp_mem [sscs_pkg::SLOTS];
   logic [sscs_pkg::ENT_W-1:0]    de_mem [sscs_pkg::SLOTS];
   logic [sscs_pkg::DATA_W-1:0]   dd_mem [sscs_pkg::SLOTS];
   logic [sscs_pkg::ENT_W-1:0]    fs_mem [sscs_pkg::MAX_ENTITIES];
   logic [sscs_pkg::SPARSE_W-1:0] sp_q;
   logic [sscs_pkg::ENT_W-1:0]    de_q;
   logic [sscs_pkg::DATA_W-1:0]   dd_q;
   logic [sscs_pkg::ENT_W-1:0]    fs_q;

   logic                          sp_we, de_we, dd_we, fs_we;
   logic [sscs_pkg::SLOT_AW-1:0]  sp_waddr, de_waddr, dd_waddr, de_raddr, sp_raddr;
   logic [sscs_pkg::SPARSE_W-1:0] sp_wdata;
   logic [sscs_pkg::ENT_W-1:0]    de_wdata, fs_waddr, fs_wdata, fs_raddr;
   logic [sscs_pkg::DATA_W-1:0]   dd_wdata;

   logic [sscs_pkg::CNT_W-1:0]    cnt_cur, last_w;
   logic                          found_w, at_last_w, dup_w, rsp_free_w, last_type_w;
   logic [sscs_pkg::ENT_W-1:0]    pq_head_w;

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entity_id = rsp_id_ff;
   assign rsp_read_data = rsp_rd_ff;
   assign rsp_free_w    = !rsp_valid_ff || rsp_ready;

   assign cnt_cur     = cnt_ff[cur_t_ff];
   assign last_w      = cnt_cur - 1'b1;
   assign found_w     = spv_ff && ({1'b0, slot_ff} < cnt_cur) && (de_q == cur_e_ff);
   assign at_last_w   = ({1'b0, slot_ff} == last_w);
   assign last_type_w = (cur_t_ff == sscs_pkg::TYPE_W'(sscs_pkg::NUM_TYPES - 1));
   assign pq_head_w   = pq_ff[idx_ff[sscs_pkg::PIDX_W-1:0]];
   assign sp_raddr    = {cur_t_ff, cur_e_ff};
   assign fs_raddr    = sscs_pkg::ENT_W'(fc_ff - 1'b1);
   assign de_raddr    = (state_ff == S_LK_SP) ? {cur_t_ff, sp_q[sscs_pkg::ENT_W-1:0]}
                                              : {cur_t_ff, last_w[sscs_pkg::ENT_W-1:0]};

   always_comb begin
      dup_w = 1'b0;
      for (int i = 0; i < sscs_pkg::PEND_DEPTH; i++) begin
         if ((sscs_pkg::PCNT_W'(i) < pc_ff) && (pq_ff[i] == cur_e_ff)) begin
            dup_w = 1'b1;
         end
      end
   end

   always_comb begin
      sp_we    = 1'b0;
      sp_waddr = {cur_t_ff, cur_e_ff};
      sp_wdata = '0;
      de_we    = 1'b0;
      de_waddr = {cur_t_ff, slot_ff};
      de_wdata = cur_e_ff;
      dd_we    = 1'b0;
      dd_waddr = {cur_t_ff, slot_ff};
      dd_wdata = data_ff;
      fs_we    = 1'b0;
      fs_waddr = fc_ff[sscs_pkg::ENT_W-1:0];
      fs_wdata = cur_e_ff;
      case (state_ff)
         S_CLEAR: begin
            sp_we    = 1'b1;
            sp_waddr = clr_ff;
         end
         S_LK_DE: begin
            if (op_ff == sscs_pkg::OP_ADD) begin
               if (found_w) begin
                  dd_we = 1'b1;
               end else if (!cnt_cur[sscs_pkg::CNT_W-1]) begin
                  // append at the end of the dense arrays
                  sp_we    = 1'b1;
                  sp_wdata = {1'b1, cnt_cur[sscs_pkg::ENT_W-1:0]};
                  de_we    = 1'b1;
                  de_waddr = {cur_t_ff, cnt_cur[sscs_pkg::ENT_W-1:0]};
                  dd_we    = 1'b1;
                  dd_waddr = {cur_t_ff, cnt_cur[sscs_pkg::ENT_W-1:0]};
               end
            end else if (op_ff != sscs_pkg::OP_READ) begin
               if (found_w && at_last_w) begin
                  sp_we = 1'b1;
               end
            end
         end
         S_RM_MOVE: begin
            // move the last dense entry into the hole
            de_we    = 1'b1;
            de_wdata = de_q;
            dd_we    = 1'b1;
            dd_wdata = dd_q;
            sp_we    = 1'b1;
            sp_waddr = {cur_t_ff, de_q};
            sp_wdata = {1'b1, slot_ff};
         end
         S_RM_INV: begin
            sp_we = 1'b1;
         end
         S_FL_PUSH: begin
            fs_we = !fc_ff[sscs_pkg::CNT_W-1];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sp_mem[sp_waddr] <= sp_wdata;
      end
      sp_q <= sp_mem[sp_raddr];
   end

   always_ff @(posedge clock) begin
      if (de_we) begin
         de_mem[de_waddr] <= de_wdata;
      end
      de_q <= de_mem[de_raddr];
   end

   always_ff @(posedge clock) begin
      if (dd_we) begin
         dd_mem[dd_waddr] <= dd_wdata;
      end
      dd_q <= dd_mem[de_raddr];
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= fs_wdata;
      end
      fs_q <= fs_mem[fs_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fc_ff        <= '0;
         hw_ff        <= '0;
         pc_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < sscs_pkg::NUM_TYPES; t++) begin
            cnt_ff[t] <= '0;
         end
      end else begin
         if (state_ff == S_RESP && rsp_free_w) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_operation;
                  cur_e_ff <= req_entity;
                  cur_t_ff <= req_component_type;
                  data_ff  <= req_component_data;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               res_rd_ff <= '0;
               case (op_ff)
                  sscs_pkg::OP_ALLOC: begin
                     if (fc_ff != '0) begin
                        res_status_ff <= sscs_pkg::ST_OK;
                        res_id_ff     <= '0;
                        fc_ff         <= fc_ff - 1'b1;
                        state_ff      <= S_ALLOC_RD;
                     end else if (!hw_ff[sscs_pkg::CNT_W-1]) begin
                        res_status_ff <= sscs_pkg::ST_OK;
                        res_id_ff     <= hw_ff[sscs_pkg::ENT_W-1:0];
                        hw_ff         <= hw_ff + 1'b1;
                        state_ff      <= S_RESP;
                     end else begin
                        res_status_ff <= sscs_pkg::ST_FULL;
                        res_id_ff     <= '0;
                        state_ff      <= S_RESP;
                     end
                  end
                  sscs_pkg::OP_ADD, sscs_pkg::OP_REMOVE, sscs_pkg::OP_READ: begin
                     res_id_ff <= '0;
                     if ({1'b0, cur_e_ff} >= hw_ff) begin
                        res_status_ff <= sscs_pkg::ST_BAD_ENT;
                        state_ff      <= S_RESP;
                     end else if ({1'b0, cur_t_ff} >=
                                  (sscs_pkg::TYPE_W+1)'(sscs_pkg::NUM_TYPES)) begin
                        res_status_ff <= sscs_pkg::ST_ABSENT;
                        state_ff      <= S_RESP;
                     end else begin
                        res_status_ff <= sscs_pkg::ST_OK;
                        state_ff      <= S_LK_SP;
                     end
                  end
                  sscs_pkg::OP_MARK: begin
                     res_id_ff <= '0;
                     state_ff  <= S_RESP;
                     if (!dup_w &&
                         (pc_ff >= sscs_pkg::PCNT_W'(sscs_pkg::PEND_DEPTH))) begin
                        res_status_ff <= sscs_pkg::ST_FULL;
                     end else begin
                        res_status_ff <= sscs_pkg::ST_OK;
                     end
                     if (!dup_w &&
                         (pc_ff < sscs_pkg::PCNT_W'(sscs_pkg::PEND_DEPTH))) begin
                        pq_ff[pc_ff[sscs_pkg::PIDX_W-1:0]] <= cur_e_ff;
                        pc_ff <= pc_ff + 1'b1;
                     end
                  end
                  sscs_pkg::OP_FLUSH: begin
                     res_status_ff <= sscs_pkg::ST_OK;
                     res_id_ff     <= '0;
                     idx_ff        <= '0;
                     state_ff      <= S_FL_ENT;
                  end
                  default: begin
                     res_status_ff <= sscs_pkg::ST_OK;
                     res_id_ff     <= '0;
                     state_ff      <= S_RESP;
                  end
               endcase
            end
            S_ALLOC_RD: begin
               res_id_ff <= fs_q;
               state_ff  <= S_RESP;
            end
            S_LK_ISSUE: begin
               state_ff <= S_LK_SP;
            end
            S_LK_SP: begin
               slot_ff  <= sp_q[sscs_pkg::ENT_W-1:0];
               spv_ff   <= sp_q[sscs_pkg::SPARSE_W-1];
               state_ff <= S_LK_DE;
            end
            S_LK_DE: begin
               if (op_ff == sscs_pkg::OP_ADD) begin
                  state_ff <= S_RESP;
                  if (!found_w) begin
                     if (cnt_cur[sscs_pkg::CNT_W-1]) begin
                        res_status_ff <= sscs_pkg::ST_FULL;
                     end else begin
                        cnt_ff[cur_t_ff] <= cnt_cur + 1'b1;
                     end
                  end
               end else if (op_ff == sscs_pkg::OP_READ) begin
                  state_ff <= S_RESP;
                  if (found_w) begin
                     res_rd_ff <= dd_q;
                  end else begin
                     res_status_ff <= sscs_pkg::ST_ABSENT;
                  end
               end else if (found_w && !at_last_w) begin
                  state_ff <= S_RM_MOVE;
               end else begin
                  if (found_w) begin
                     cnt_ff[cur_t_ff] <= last_w;
                  end
                  if (op_ff == sscs_pkg::OP_REMOVE) begin
                     state_ff <= S_RESP;
                     if (!found_w) begin
                        res_status_ff <= sscs_pkg::ST_ABSENT;
                     end
                  end else if (!last_type_w) begin
                     cur_t_ff <= cur_t_ff + 1'b1;
                     state_ff <= S_LK_ISSUE;
                  end else begin
                     state_ff <= S_FL_PUSH;
                  end
               end
            end
            S_RM_MOVE: begin
               state_ff <= S_RM_INV;
            end
            S_RM_INV: begin
               cnt_ff[cur_t_ff] <= last_w;
               if (op_ff == sscs_pkg::OP_REMOVE) begin
                  state_ff <= S_RESP;
               end else if (!last_type_w) begin
                  cur_t_ff <= cur_t_ff + 1'b1;
                  state_ff <= S_LK_ISSUE;
               end else begin
                  state_ff <= S_FL_PUSH;
               end
            end
            S_FL_ENT: begin
               if (idx_ff >= pc_ff) begin
                  pc_ff    <= '0;
                  state_ff <= S_RESP;
               end else if ({1'b0, pq_head_w} >= hw_ff) begin
                  // skip entities beyond the high-water mark
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  cur_e_ff <= pq_head_w;
                  cur_t_ff <= '0;
                  state_ff <= S_LK_ISSUE;
               end
            end
            S_FL_PUSH: begin
               if (!fc_ff[sscs_pkg::CNT_W-1]) begin
                  fc_ff <= fc_ff + 1'b1;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_FL_ENT;
            end
            S_RESP: begin
               if (rsp_free_w) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result payload, loaded when the output register takes a new transfer
   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && rsp_free_w) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_rd_ff     <= res_rd_ff;
      end
   end

endmodule

FILE: hw/rtl/sscs_checker.sv
// Port-level checks for the sparse-set component store, bound to the top level.
// Depends on sscs_pkg and sparse_set_component_store_top.
module sscs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sscs_pkg::STATUS_W-1:0] rsp_status,
   input logic [sscs_pkg::ENT_W-1:0]    rsp_entity_id,
   input logic [sscs_pkg::DATA_W-1:0]   rsp_read_data
);

   // clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("req_ready high right after reset");

   // one item at a time: an accepted transfer closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   a_error_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != sscs_pkg::ST_OK) |->
      (rsp_entity_id == '0 && rsp_read_data == '0))
      else $error("failed result carries payload");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_entity_id) &&
       $stable(rsp_read_data)))
      else $error("stalled result changed");

endmodule

bind sparse_set_component_store_top sscs_checker u_sscs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_entity_id (rsp_entity_id),
   .rsp_read_data (rsp_read_data)
);
